FILE: hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the timestamp stream pairer
// Field widths, queue geometry, reset tolerance, stream select codes, queue
// entry, control and status types, sequencer states.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Field widths
  localparam int TIME_W = 63;
  localparam int TAG_W  = 16;

  // Queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // Tolerance after reset
  localparam logic [TIME_W-1:0] TOL_RESET = TIME_W'(16666666);

  // Stream select codes
  localparam logic CMD_DEPTH = 1'b0;
  localparam logic CMD_COLOR = 1'b1;

  // One frame descriptor as held in a queue
  typedef struct packed {
    logic [TIME_W-1:0] ftime;
    logic [TAG_W-1:0]  tag;
  } tsp_entry_t;

  // Queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } tsp_qctrl_t;

  // Queue status to the sequencer
  typedef struct packed {
    logic empty;
  } tsp_qstat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP_D,
    ST_CMP_C,
    ST_EMIT
  } tsp_state_e;

endpackage

FILE: hw/rtl/tsp_queue.sv
// ----------------------------------------------------------------------------
// tsp_queue: bounded frame queue of one stream
// Circular store with head pointer and fill count. A push onto a full queue
// overwrites the oldest entry. The head entry is read into a register on
// request.
// ----------------------------------------------------------------------------
module tsp_queue import tsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tsp_qctrl_t ctrl_i,
  input  tsp_entry_t push_entry_i,
  output tsp_entry_t head_entry_o,
  output tsp_qstat_t stat_o
);

  tsp_entry_t           mem [QUEUE_DEPTH];
  tsp_entry_t           rd_q;
  logic [QAW-1:0]       head_q, head_d;
  logic [QCW-1:0]       count_q, count_d;
  logic                 full;
  logic [QAW:0]         wsum;
  logic [QAW-1:0]       waddr;
  logic [QAW-1:0]       head_inc;

  assign full = (count_q == QCW'(QUEUE_DEPTH));

  // Advance head with wrap
  assign head_inc = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);

  // Tail slot: head plus count, wrapped; a full queue writes over its head
  assign wsum  = {1'b0, head_q} + {1'b0, count_q[QAW-1:0]};
  always_comb begin
    if (full) begin
      waddr = head_q;
    end else if (wsum >= (QAW+1)'(QUEUE_DEPTH)) begin
      waddr = QAW'(wsum - (QAW+1)'(QUEUE_DEPTH));
    end else begin
      waddr = wsum[QAW-1:0];
    end
  end

  // Pointer and count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      if (full) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + QCW'(1);
      end
    end else if (ctrl_i.pop && (count_q != '0)) begin
      head_d  = head_inc;
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Store write and registered head read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[waddr] <= push_entry_i;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem[head_q];
    end
  end

  assign head_entry_o = rd_q;
  assign stat_o.empty = (count_q == '0);

endmodule

FILE: hw/rtl/tsp_cmp.sv
// ----------------------------------------------------------------------------
// tsp_cmp: shared timestamp compare unit
// Flags when the first timestamp plus the tolerance is strictly below the
// second; the sum is formed one bit wider so it never wraps.
// ----------------------------------------------------------------------------
module tsp_cmp import tsp_pkg::*; (
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  input  logic [TIME_W-1:0] tol_i,
  output logic              older_o
);

  logic [TIME_W:0] sum;

  // Widen, add, compare
  assign sum     = {1'b0, a_i} + {1'b0, tol_i};
  assign older_o = (sum < {1'b0, b_i});

endmodule

FILE: hw/rtl/timestamp_stream_pairer.sv
// ----------------------------------------------------------------------------
// timestamp_stream_pairer: pairs depth and colour frames by capture time
// Flow: an input transfer moves the sequencer through READ, CMP_D, CMP_C and
//   EMIT before the pair is loaded into the output register; a discarded depth
//   head repeats READ and CMP_D, a discarded colour head READ, CMP_D and CMP_C;
//   a held output keeps the sequencer in EMIT. The sequencer reuses one compare
//   unit and stalls the input outside IDLE, so a frame is taken only when idle.
// Reset: queues empty, tolerance 16666666, output register empty.
// ----------------------------------------------------------------------------
module timestamp_stream_pairer import tsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TIME_W-1:0] cfg_data_i,
  // Frame descriptor input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [TIME_W-1:0] arrival_time_i,
  input  logic [TAG_W-1:0]  frame_tag_i,
  // Pair output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TAG_W-1:0]  depth_frame_tag_o,
  output logic [TAG_W-1:0]  color_frame_tag_o,
  output logic [TIME_W-1:0] depth_frame_time_o,
  output logic [TIME_W-1:0] color_frame_time_o
);

  tsp_state_e        state_q, state_d;
  logic [TIME_W-1:0] tol_q;
  tsp_qctrl_t        dctrl, cctrl;
  tsp_qstat_t        dstat, cstat;
  tsp_entry_t        in_entry, dhead, chead;
  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              older;
  logic              in_xfer;
  logic              out_free;
  logic              load_out;

  logic              out_valid_q;
  tsp_entry_t        out_depth_q, out_color_q;

  // Tolerance register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign in_entry.ftime = arrival_time_i;
  assign in_entry.tag   = frame_tag_i;
  assign out_free       = !out_valid_q || !out_stall_i;

  // Queues
  tsp_queue u_depth_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dctrl),
    .push_entry_i (in_entry),
    .head_entry_o (dhead),
    .stat_o       (dstat)
  );

  tsp_queue u_color_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (cctrl),
    .push_entry_i (in_entry),
    .head_entry_o (chead),
    .stat_o       (cstat)
  );

  // Shared compare: depth against colour first, then the other way round
  assign cmp_a = (state_q == ST_CMP_C) ? chead.ftime : dhead.ftime;
  assign cmp_b = (state_q == ST_CMP_C) ? dhead.ftime : chead.ftime;

  tsp_cmp u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .tol_i   (tol_q),
    .older_o (older)
  );

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and queue controls
  always_comb begin
    state_d  = state_q;
    dctrl    = '0;
    cctrl    = '0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          dctrl.push = (command_i == CMD_DEPTH);
          cctrl.push = (command_i == CMD_COLOR);
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        if (dstat.empty || cstat.empty) begin
          state_d = ST_IDLE;
        end else begin
          dctrl.rd = 1'b1;
          cctrl.rd = 1'b1;
          state_d  = ST_CMP_D;
        end
      end
      ST_CMP_D: begin
        if (older) begin
          dctrl.pop = 1'b1;
          state_d   = ST_READ;
        end else begin
          state_d = ST_CMP_C;
        end
      end
      ST_CMP_C: begin
        if (older) begin
          cctrl.pop = 1'b1;
          state_d   = ST_READ;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          dctrl.pop = 1'b1;
          cctrl.pop = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load a pair, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_depth_q <= dhead;
      out_color_q <= chead;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign depth_frame_tag_o  = out_depth_q.tag;
  assign color_frame_tag_o  = out_color_q.tag;
  assign depth_frame_time_o = out_depth_q.ftime;
  assign color_frame_time_o = out_color_q.ftime;

endmodule

FILE: tb/timestamp_stream_pairer_tb.sv
// ----------------------------------------------------------------------------
// timestamp_stream_pairer_tb: self-checking bench for the frame pairer
// Feeds depth and colour frame descriptors and tracks both stream queues in a
// scoreboard that predicts each pair. Every pair transfer is checked field by
// field. Directed edge cases come first, then random runs under several
// tolerance settings and idle patterns, including one long output hold.
// ----------------------------------------------------------------------------
module timestamp_stream_pairer_tb;
  import tsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 232;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One expected pair
  typedef struct {
    logic [TAG_W-1:0]  dtag;
    logic [TAG_W-1:0]  ctag;
    logic [TIME_W-1:0] dtime;
    logic [TIME_W-1:0] ctime;
  } frame_pair_t;

  // Tracks both stream queues and the pairs they must produce
  class pair_scoreboard;
    tsp_entry_t        depth_fifo[$];
    tsp_entry_t        color_fifo[$];
    frame_pair_t       pending_pairs[$];
    logic [TIME_W-1:0] tolerance;
    int                errors;
    int                pairs_checked;
    int                discards;
    int                overflows;

    function new();
      tolerance = TOL_RESET;
      errors = 0;
      pairs_checked = 0;
      discards = 0;
      overflows = 0;
    endfunction

    // Queue the frame, then drop stale heads until a pair forms or a queue empties
    function void accept_frame(logic cmd, logic [TIME_W-1:0] t, logic [TAG_W-1:0] tag);
      tsp_entry_t        e;
      frame_pair_t       p;
      logic [TIME_W:0]   d_sum;
      logic [TIME_W:0]   c_sum;
      e.ftime = t;
      e.tag = tag;
      if (cmd == CMD_DEPTH) begin
        if (depth_fifo.size() == QUEUE_DEPTH) begin
          depth_fifo.delete(0);
          overflows++;
        end
        depth_fifo.insert(depth_fifo.size(), e);
      end else begin
        if (color_fifo.size() == QUEUE_DEPTH) begin
          color_fifo.delete(0);
          overflows++;
        end
        color_fifo.insert(color_fifo.size(), e);
      end
      while (depth_fifo.size() != 0 && color_fifo.size() != 0) begin
        d_sum = {1'b0, depth_fifo[0].ftime} + {1'b0, tolerance};
        c_sum = {1'b0, color_fifo[0].ftime} + {1'b0, tolerance};
        if (d_sum < {1'b0, color_fifo[0].ftime}) begin
          depth_fifo.delete(0);
          discards++;
        end else if (c_sum < {1'b0, depth_fifo[0].ftime}) begin
          color_fifo.delete(0);
          discards++;
        end else begin
          p.dtag = depth_fifo[0].tag;
          p.ctag = color_fifo[0].tag;
          p.dtime = depth_fifo[0].ftime;
          p.ctime = color_fifo[0].ftime;
          pending_pairs.insert(pending_pairs.size(), p);
          depth_fifo.delete(0);
          color_fifo.delete(0);
          break;
        end
      end
    endfunction

    // Compare one pair transfer with the oldest expected pair
    function void check_pair(logic [TAG_W-1:0] dtag, logic [TAG_W-1:0] ctag,
                             logic [TIME_W-1:0] dtime, logic [TIME_W-1:0] ctime);
      frame_pair_t want;
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair transfer: depth tag %0d, colour tag %0d", dtag, ctag);
        errors++;
        return;
      end
      want = pending_pairs[0];
      pending_pairs.delete(0);
      if (dtag !== want.dtag) begin
        $error("depth_frame_tag: expected %0d, actual %0d", want.dtag, dtag);
        errors++;
      end
      if (ctag !== want.ctag) begin
        $error("color_frame_tag: expected %0d, actual %0d", want.ctag, ctag);
        errors++;
      end
      if (dtime !== want.dtime) begin
        $error("depth_frame_time: expected %0d, actual %0d", want.dtime, dtime);
        errors++;
      end
      if (ctime !== want.ctime) begin
        $error("color_frame_time: expected %0d, actual %0d", want.ctime, ctime);
        errors++;
      end
      pairs_checked++;
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [TIME_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              command_i = CMD_DEPTH;
  logic [TIME_W-1:0] arrival_time_i = '0;
  logic [TAG_W-1:0]  frame_tag_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [TAG_W-1:0]  depth_frame_tag_o;
  logic [TAG_W-1:0]  color_frame_tag_o;
  logic [TIME_W-1:0] depth_frame_time_o;
  logic [TIME_W-1:0] color_frame_time_o;

  pair_scoreboard sb = new();
  int  send_idle_pct = 34;
  int  recv_idle_pct = 47;
  bit  request_hold = 1'b0;
  int  frames_in = 0;
  int  tolerance_settings = 1;
  int  cycle_count = 0;

  timestamp_stream_pairer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .arrival_time_i     (arrival_time_i),
    .frame_tag_i        (frame_tag_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .depth_frame_tag_o  (depth_frame_tag_o),
    .color_frame_tag_o  (color_frame_tag_o),
    .depth_frame_time_o (depth_frame_time_o),
    .color_frame_time_o (color_frame_time_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Offer one frame, idling at random first, and hold it until the transfer
  task automatic send_frame(input logic cmd, input logic [TIME_W-1:0] t,
                            input logic [TAG_W-1:0] tag);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    arrival_time_i <= t;
    frame_tag_i    <= tag;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    sb.accept_frame(cmd, t, tag);
    frames_in++;
  endtask

  // Let every expected pair out, then let trailing head drops finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TIME_W-1:0] v);
    logic ready;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready);
    cfg_valid_i <= 1'b0;
    sb.tolerance = v;
    tolerance_settings++;
  endtask

  // Mostly interleaved depth/colour runs with jitter around the tolerance,
  // plus single-stream bursts that overflow a queue and raw noise
  task automatic run_phase(input int n_items);
    int          sent;
    int          pick;
    int          len;
    int          k;
    logic [63:0] unit;
    logic [63:0] period;
    logic [63:0] base;
    logic [63:0] span;
    logic [63:0] d_t;
    logic [63:0] c_t;
    logic [63:0] mag;
    logic        cmd;
    bit          skip_d;
    bit          skip_c;
    bit          colour_first;
    sent = 0;
    unit = (sb.tolerance > TIME_W'(1000000000)) ? 64'd1000000000 : {1'b0, sb.tolerance};
    period = 2 * unit + 1;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      len = (pick < 80) ? $urandom_range(4, 24) : (pick < 86) ? $urandom_range(60, 80)
                                                              : $urandom_range(1, 8);
      span = 64'(len) * period + unit + 2;
      base = {1'b0, rand_time()};
      if (base < unit + 2) base = unit + 2;
      if (base > {1'b0, TIME_MAX} - span) base = {1'b0, TIME_MAX} - span;
      cmd = $urandom_range(0, 1) ? CMD_COLOR : CMD_DEPTH;
      for (k = 0; k < len; k++) begin
        d_t = base + 64'(k) * period;
        if (pick < 80) begin
          case ($urandom_range(0, 5))
            0: mag = unit;
            1: mag = unit + 1;
            2: mag = 0;
            default: mag = 64'($urandom_range(0, 32'(unit + 2)));
          endcase
          c_t = $urandom_range(0, 1) ? d_t - mag : d_t + mag;
          skip_d = $urandom_range(0, 99) < 12;
          skip_c = $urandom_range(0, 99) < 12;
          colour_first = $urandom_range(0, 1);
          if (colour_first && !skip_c) send_frame(CMD_COLOR, c_t[TIME_W-1:0], TAG_W'($urandom));
          if (!skip_d) send_frame(CMD_DEPTH, d_t[TIME_W-1:0], TAG_W'($urandom));
          if (!colour_first && !skip_c) send_frame(CMD_COLOR, c_t[TIME_W-1:0], TAG_W'($urandom));
          sent += 2;
        end else if (pick < 86) begin
          send_frame(cmd, d_t[TIME_W-1:0], TAG_W'($urandom));
          sent++;
        end else begin
          send_frame(1'($urandom), rand_time(), TAG_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Check pair transfers and drive the output stall
  initial begin : pair_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        sb.check_pair(depth_frame_tag_o, color_frame_tag_o,
                      depth_frame_time_o, color_frame_time_o);
      end
      @(posedge clk_i);
      if (request_hold) begin
        request_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d pairs outstanding",
           cycle_count, sb.pending_pairs.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [TIME_W-1:0] tol_r;
    tol_r = TOL_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tolerance edges both ways, extreme times and tags
    send_frame(CMD_DEPTH, '0, '0);
    send_frame(CMD_COLOR, tol_r, '1);
    send_frame(CMD_COLOR, TIME_W'(100), TAG_W'(1));
    send_frame(CMD_DEPTH, TIME_W'(101) + tol_r, TAG_W'(2));
    send_frame(CMD_COLOR, TIME_W'(201) + tol_r, TAG_W'(3));
    send_frame(CMD_DEPTH, TIME_MAX, '1);
    send_frame(CMD_COLOR, TIME_MAX, '0);
    send_frame(CMD_DEPTH, TIME_MAX - tol_r, TAG_W'(4));
    send_frame(CMD_COLOR, TIME_MAX, TAG_W'(5));
    send_frame(CMD_COLOR, '0, TAG_W'(6));
    send_frame(CMD_DEPTH, TIME_MAX, TAG_W'(7));
    send_frame(CMD_COLOR, TIME_MAX - tol_r - 1, TAG_W'(8));
    send_frame(CMD_COLOR, TIME_MAX - tol_r, TAG_W'(9));

    // Random phases: sender idles less than receiver, then the reverse, then none
    run_phase(PHASE_ITEMS);
    wait_idle();
    write_tolerance('0);
    run_phase(PHASE_ITEMS);

    wait_idle();
    send_idle_pct = 47;
    recv_idle_pct = 34;
    write_tolerance(TIME_MAX);
    run_phase(PHASE_ITEMS);
    wait_idle();
    write_tolerance(TIME_W'($urandom));
    run_phase(PHASE_ITEMS);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(rand_time());
    request_hold = 1'b1;
    run_phase(PHASE_ITEMS);
    wait_idle();
    write_tolerance(TIME_W'($urandom_range(1, 2000)));
    run_phase(PHASE_ITEMS);
    wait_idle();

    $display("Run: %0d frames in, %0d pairs checked, %0d tolerance settings",
             frames_in, sb.pairs_checked, tolerance_settings);
    $display("Queue overflows %0d, stale heads dropped %0d, one long output hold",
             sb.overflows, sb.discards);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
